FILE: hdl/vad_pkg.sv
package vad_pkg;

    localparam int COORD_WIDTH_DEF         = 24;
    localparam int ANGLE_FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF         = 4;
    localparam int REDUCE_BITS             = 30;
    localparam int N_W                     = 128;
    localparam int D_W                     = 64;
    localparam int N_SCALE                 = 124;
    localparam int D_SCALE                 = 62;
    localparam int RAD_W                   = 64;
    localparam int ROOT_W                  = 32;
    localparam int XM_W                    = 32;
    localparam int G_W                     = 7;
    localparam int ZFRAC                   = 24;
    localparam int CORDIC_STEPS            = 28;
    localparam int CX_W                    = 34;
    localparam int ANGLE_W                 = 16;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic signed [CX_W-1:0] atan_val(input int idx);
        logic signed [CX_W-1:0] v;
        case (idx)
            0:  v = CX_W'(754974720);
            1:  v = CX_W'(445687602);
            2:  v = CX_W'(235489088);
            3:  v = CX_W'(119537938);
            4:  v = CX_W'(60000934);
            5:  v = CX_W'(30029717);
            6:  v = CX_W'(15018523);
            7:  v = CX_W'(7509720);
            8:  v = CX_W'(3754917);
            9:  v = CX_W'(1877466);
            10: v = CX_W'(938734);
            11: v = CX_W'(469367);
            12: v = CX_W'(234684);
            13: v = CX_W'(117342);
            14: v = CX_W'(58671);
            15: v = CX_W'(29335);
            16: v = CX_W'(14668);
            17: v = CX_W'(7334);
            18: v = CX_W'(3667);
            19: v = CX_W'(1833);
            20: v = CX_W'(917);
            21: v = CX_W'(458);
            22: v = CX_W'(229);
            23: v = CX_W'(115);
            24: v = CX_W'(57);
            25: v = CX_W'(29);
            26: v = CX_W'(14);
            27: v = CX_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] bitlen16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: hdl/vad_front.sv
module vad_front #(
    parameter int CW = vad_pkg::COORD_WIDTH_DEF,
    parameter int RW = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [9*CW-1:0]     i_data,
    output logic                o_push,
    input  vad_pkg::t_q_status  i_q_stat,
    output logic [6*RW:0]       o_item
);
    import vad_pkg::*;

    localparam int DW    = CW + 1;
    localparam int SHMAX = (DW > REDUCE_BITS + 1) ? DW - REDUCE_BITS - 1 : 0;

    logic signed [CW-1:0] f [9];
    logic signed [DW-1:0] d [2][3];
    logic                 zero_in;
    logic                 en;

    logic                 r_s1_valid;
    logic signed [DW-1:0] r_d1 [2][3];
    logic                 r_z1;
    logic                 r_s2_valid;
    logic [6*RW:0]        r_item;

    logic [DW-1:0]        mg [2][3];
    logic [DW-1:0]        mx [2];
    logic [1:0]           sh [2];
    logic [DW-1:0]        red;
    logic [RW-1:0]        rv [2][3];
    logic [6*RW:0]        n_item;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            f[k] = i_data[k*CW +: CW];
        end
        for (int k = 0; k < 3; k++) begin
            d[0][k] = DW'(f[k]) - DW'(f[3+k]);
            d[1][k] = DW'(f[6+k]) - DW'(f[3+k]);
        end
        zero_in = (d[0][0] == '0 && d[0][1] == '0 && d[0][2] == '0) ||
                  (d[1][0] == '0 && d[1][1] == '0 && d[1][2] == '0);
    end

    // per-vector range reduction
    always_comb begin
        red = '0;
        for (int v = 0; v < 2; v++) begin
            for (int k = 0; k < 3; k++) begin
                mg[v][k] = r_d1[v][k][DW-1] ? DW'(-r_d1[v][k]) : DW'(r_d1[v][k]);
            end
            mx[v] = mg[v][0];
            if (mg[v][1] > mx[v]) begin
                mx[v] = mg[v][1];
            end
            if (mg[v][2] > mx[v]) begin
                mx[v] = mg[v][2];
            end
            sh[v] = '0;
            for (int s = SHMAX; s >= 0; s--) begin
                if (64'(mx[v] >> s) <= (64'd1 << REDUCE_BITS)) begin
                    sh[v] = 2'(s);
                end
            end
            for (int k = 0; k < 3; k++) begin
                red = mg[v][k] >> sh[v];
                rv[v][k] = r_d1[v][k][DW-1] ? -RW'(red) : RW'(red);
            end
        end
        n_item = {r_z1, rv[1][2], rv[1][1], rv[1][0], rv[0][2], rv[0][1], rv[0][0]};
    end

    assign en      = !(r_s2_valid && i_q_stat.full);
    assign o_ready = en;
    assign o_push  = r_s2_valid && !i_q_stat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1   <= d;
            r_z1   <= zero_in;
            r_item <= n_item;
        end
    end

endmodule

FILE: hdl/vad_queue.sv
module vad_queue #(
    parameter int W     = 151,
    parameter int DEPTH = vad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [W-1:0]        i_data,
    input  logic                i_pop,
    output logic [W-1:0]        o_data,
    output vad_pkg::t_q_status  o_stat
);
    import vad_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/vad_sqrt.sv
module vad_sqrt #(
    parameter int SIDE_W = 34
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [vad_pkg::RAD_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [vad_pkg::ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]           o_side
);
    import vad_pkg::*;

    localparam int REM_W = RAD_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic              r_v    [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;

        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic              v_in;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign rem_in  = REM_W'(i_rad);
            assign root_in = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign side_in = r_side[j-1];
            assign v_in    = r_v[j-1];
        end

        // (r + 2^b)^2 - r^2
        always_comb begin
            trial = (REM_W'(root_in) << (B + 1)) + (REM_W'(1) << (2 * B));
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (ROOT_W'(1) << B);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: hdl/vad_cordic.sv
module vad_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic                              i_zero,
    input  logic                              i_neg,
    input  logic [vad_pkg::XM_W-1:0]          i_xm,
    input  logic [vad_pkg::ROOT_W-1:0]        i_root,
    output logic                              o_valid,
    output logic                              o_zero,
    output logic signed [vad_pkg::CX_W-1:0]   o_z
);
    import vad_pkg::*;

    localparam int S = CORDIC_STEPS;

    logic signed [CX_W-1:0] r_x [S+1];
    logic signed [CX_W-1:0] r_y [S+1];
    logic signed [CX_W-1:0] r_z [S+1];
    logic                   r_f [S+1];
    logic                   r_v [S+1];

    logic signed [CX_W-1:0] xe;
    logic signed [CX_W-1:0] x0;
    logic signed [CX_W-1:0] y0;
    logic signed [CX_W-1:0] n_x0;
    logic signed [CX_W-1:0] n_y0;
    logic signed [CX_W-1:0] n_z0;

    // left half-plane: pre-rotate by -90 degrees
    always_comb begin
        xe = CX_W'(i_xm);
        x0 = i_neg ? -xe : xe;
        y0 = CX_W'(i_root);
        if (x0 < 0) begin
            n_x0 = y0;
            n_y0 = -x0;
            n_z0 = CX_W'(90) <<< ZFRAC;
        end else begin
            n_x0 = x0;
            n_y0 = y0;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
            r_f[0] <= i_zero;
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_step
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        logic signed [CX_W-1:0] n_x;
        logic signed [CX_W-1:0] n_y;
        logic signed [CX_W-1:0] n_z;

        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            if (r_y[i] >= 0) begin
                n_x = r_x[i] + ys;
                n_y = r_y[i] - xs;
                n_z = r_z[i] + atan_val(i);
            end else begin
                n_x = r_x[i] - ys;
                n_y = r_y[i] + xs;
                n_z = r_z[i] - atan_val(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
                r_f[i+1] <= r_f[i];
            end
        end
    end

    assign o_valid = r_v[S];
    assign o_zero  = r_f[S];
    assign o_z     = r_z[S];

endmodule

FILE: hdl/vad_back.sv
module vad_back #(
    parameter int RW = 25,
    parameter int AF = vad_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vad_pkg::t_q_status            i_q_stat,
    input  logic [6*RW:0]                 i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vad_pkg::ANGLE_W-1:0]   o_angle,
    output logic                          o_zero
);
    import vad_pkg::*;

    localparam int PW   = 2 * RW;
    localparam int CPW  = 2 * RW + 1;
    localparam int DTW  = 2 * RW + 2;
    localparam int NCH  = N_W / 16;
    localparam int DCH  = D_W / 16;
    localparam int SH   = ZFRAC - AF;
    localparam int SIDE_W = XM_W + 2;
    localparam logic signed [CX_W-1:0] Z_LIM  = CX_W'(64'd180 << ZFRAC);
    localparam logic [CX_W-1:0]        Z_HALF = CX_W'(64'd1 << (SH - 1));

    logic                 en;
    logic signed [RW-1:0] a [3];
    logic signed [RW-1:0] b [3];

    logic [9:1]           r_v;
    logic [9:1]           r_zf;

    logic signed [PW-1:0]  r1_p [9];
    logic signed [CPW-1:0] r2_c [3];
    logic signed [DTW-1:0] r2_d;
    logic [PW-1:0]         r3_cm [3];
    logic [PW-1:0]         r3_dm;
    logic [PW-1:0]         r4_hh [3];
    logic [PW-1:0]         r4_hl [3];
    logic [PW-1:0]         r4_ll [3];
    logic [PW-1:0]         r4_dm;
    logic [N_W-1:0]        r5_sq [3];
    logic [D_W-1:0]        r5_dm;
    logic [N_W-1:0]        r6_n;
    logic [D_W-1:0]        r6_dm;
    logic [4:0]            r7_nl [NCH];
    logic [4:0]            r7_dl [DCH];
    logic [N_W-1:0]        r7_n;
    logic [D_W-1:0]        r7_dm;
    logic [G_W-1:0]        r8_g;
    logic [N_W-1:0]        r8_n;
    logic [D_W-1:0]        r8_dm;
    logic [RAD_W-1:0]      r9_rad;
    logic [XM_W-1:0]       r9_xm;
    logic [9:3]            r_ds;

    logic signed [CPW-1:0] ca [3];
    logic signed [DTW-1:0] da;
    logic [7:0]            bn;
    logic [7:0]            bd;
    logic [7:0]            g1;
    logic [7:0]            g2;
    logic [G_W-1:0]        n_g;
    logic [N_W-1:0]        sn;
    logic [D_W-1:0]        sd;

    logic                  s_valid;
    logic [ROOT_W-1:0]     s_root;
    logic [SIDE_W-1:0]     s_side;

    logic                  c_valid;
    logic                  c_zero;
    logic signed [CX_W-1:0] c_z;
    logic signed [CX_W-1:0] zc;
    logic [CX_W-1:0]       zr;
    logic [ANGLE_W-1:0]    n_angle;

    logic                  r_out_valid;
    logic [ANGLE_W-1:0]    r_angle;
    logic                  r_zero;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_q_stat.empty;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a[k] = i_item[k*RW +: RW];
            b[k] = i_item[(3+k)*RW +: RW];
        end
        for (int k = 0; k < 3; k++) begin
            ca[k] = (r2_c[k] < 0) ? -r2_c[k] : r2_c[k];
        end
        da = (r2_d < 0) ? -r2_d : r2_d;

        // bit lengths from the per-chunk counts
        bn = '0;
        for (int k = 0; k < NCH; k++) begin
            if (r7_nl[k] != '0) begin
                bn = 8'(16 * k) + 8'(r7_nl[k]);
            end
        end
        bd = '0;
        for (int k = 0; k < DCH; k++) begin
            if (r7_dl[k] != '0) begin
                bd = 8'(16 * k) + 8'(r7_dl[k]);
            end
        end
        g1  = (8'(N_SCALE) - bn) >> 1;
        g2  = 8'(D_SCALE) - bd;
        n_g = (g2 < g1) ? G_W'(g2) : G_W'(g1);

        sn = r8_n << {r8_g, 1'b0};
        sd = r8_dm << r8_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[8:1], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zf <= {r_zf[8:1], i_item[6*RW]};

            r1_p[0] <= PW'(a[1]) * PW'(b[2]);
            r1_p[1] <= PW'(a[2]) * PW'(b[1]);
            r1_p[2] <= PW'(a[2]) * PW'(b[0]);
            r1_p[3] <= PW'(a[0]) * PW'(b[2]);
            r1_p[4] <= PW'(a[0]) * PW'(b[1]);
            r1_p[5] <= PW'(a[1]) * PW'(b[0]);
            r1_p[6] <= PW'(a[0]) * PW'(b[0]);
            r1_p[7] <= PW'(a[1]) * PW'(b[1]);
            r1_p[8] <= PW'(a[2]) * PW'(b[2]);

            r2_c[0] <= CPW'(r1_p[0]) - CPW'(r1_p[1]);
            r2_c[1] <= CPW'(r1_p[2]) - CPW'(r1_p[3]);
            r2_c[2] <= CPW'(r1_p[4]) - CPW'(r1_p[5]);
            r2_d    <= DTW'(r1_p[6]) + DTW'(r1_p[7]) + DTW'(r1_p[8]);

            for (int k = 0; k < 3; k++) begin
                r3_cm[k] <= ca[k][PW-1:0];
            end
            r3_dm <= da[PW-1:0];
            r_ds  <= {r_ds[8:3], r2_d[DTW-1]};

            // squares split into half-width partial products
            for (int k = 0; k < 3; k++) begin
                r4_hh[k] <= PW'(r3_cm[k][PW-1:RW]) * PW'(r3_cm[k][PW-1:RW]);
                r4_hl[k] <= PW'(r3_cm[k][PW-1:RW]) * PW'(r3_cm[k][RW-1:0]);
                r4_ll[k] <= PW'(r3_cm[k][RW-1:0]) * PW'(r3_cm[k][RW-1:0]);
            end
            r4_dm <= r3_dm;

            for (int k = 0; k < 3; k++) begin
                r5_sq[k] <= (N_W'(r4_hh[k]) << PW) + (N_W'(r4_hl[k]) << (RW + 1)) +
                            N_W'(r4_ll[k]);
            end
            r5_dm <= D_W'(r4_dm);

            r6_n  <= r5_sq[0] + r5_sq[1] + r5_sq[2];
            r6_dm <= r5_dm;

            for (int k = 0; k < NCH; k++) begin
                r7_nl[k] <= bitlen16(r6_n[16*k +: 16]);
            end
            for (int k = 0; k < DCH; k++) begin
                r7_dl[k] <= bitlen16(r6_dm[16*k +: 16]);
            end
            r7_n  <= r6_n;
            r7_dm <= r6_dm;

            r8_g  <= n_g;
            r8_n  <= r7_n;
            r8_dm <= r7_dm;

            r9_rad <= sn[N_W-1 -: RAD_W];
            r9_xm  <= sd[D_W-1 -: XM_W];
        end
    end

    vad_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[9]),
        .i_rad   (r9_rad),
        .i_side  ({r_zf[9], r_ds[9], r9_xm}),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    vad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_zero  (s_side[SIDE_W-1]),
        .i_neg   (s_side[SIDE_W-2]),
        .i_xm    (s_side[XM_W-1:0]),
        .i_root  (s_root),
        .o_valid (c_valid),
        .o_zero  (c_zero),
        .o_z     (c_z)
    );

    always_comb begin
        if (c_z < 0) begin
            zc = '0;
        end else if (c_z > Z_LIM) begin
            zc = Z_LIM;
        end else begin
            zc = c_z;
        end
        zr      = (CX_W'(zc) + Z_HALF) >> SH;
        n_angle = c_zero ? '0 : zr[ANGLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_angle <= n_angle;
            r_zero  <= c_zero;
        end
    end

    assign o_valid = r_out_valid;
    assign o_angle = r_angle;
    assign o_zero  = r_zero;

endmodule

FILE: hdl/vector_angle_degrees_unit.sv
// Angle at vertex V between A-V and C-V (tie V to zero for the plain angle
// between two vectors), returned in units of 2^-ANGLE_FRACTION_BITS degree
// over 0 to 180 degrees. The angle is found as atan2(|a x b|, a.b) with a
// pipelined square root and a 28-step CORDIC, so no cosine is ever formed.
// A zero-length vector gives angle 0 with the zero_length flag set. One item
// per clock is taken and one result per clock is delivered unless the output
// stalls. From input transfer to output valid an item passes the 2 input
// stages, the queue, the 9 product and scaling stages, the 32-stage root and
// the 29-stage CORDIC pipeline, plus the output register.
// A small queue between the input stages and the arithmetic pipeline absorbs
// a few transfers while the output is stalled; the input then stalls too.
module vector_angle_degrees_unit #(
    parameter int COORD_WIDTH         = vad_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRACTION_BITS = vad_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH         = vad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // point_a_x, point_a_y, point_a_z, vertex_x, vertex_y, vertex_z,
    // point_c_x, point_c_y, point_c_z, zero pad
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // angle_deg
    output logic [vad_pkg::ANGLE_W-1:0]        m_axis_tdata,
    // zero_length
    output logic [0:0]                         m_axis_tuser
);
    import vad_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int RW = (DW < 32) ? DW : 32;
    localparam int IW = 6 * RW + 1;

    logic          push;
    logic          pop;
    logic [IW-1:0] f_item;
    logic [IW-1:0] q_item;
    t_q_status     q_stat;

    vad_front #(
        .CW (COORD_WIDTH),
        .RW (RW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata[9*COORD_WIDTH-1:0]),
        .o_push   (push),
        .i_q_stat (q_stat),
        .o_item   (f_item)
    );

    vad_queue #(
        .W     (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_stat  (q_stat)
    );

    vad_back #(
        .RW (RW),
        .AF (ANGLE_FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_item   (q_item),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_angle  (m_axis_tdata),
        .o_zero   (m_axis_tuser[0])
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CW      = vad_pkg::COORD_WIDTH_DEF;
    localparam int AFB     = vad_pkg::ANGLE_FRACTION_BITS_DEF;
    localparam int DATA_W  = ((9*CW+7)/8)*8;
    localparam int ZF      = 24;
    localparam int STEPS   = 28;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [15:0] angle;
        logic        zero_len;
    } angle_result_t;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t points_t [9];

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;   // point_a_x/y/z, vertex_x/y/z, point_c_x/y/z, pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // angle_deg
    logic [0:0]            m_axis_tuser;   // zero_length

    angle_result_t expected_angles[$];
    int            error_count;
    longint        cycle_count;
    bit            send_idle_on;
    bit            recv_idle_on;
    bit            long_hold;

    vector_angle_degrees_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int bit_length(logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic longint atan_step(int i);
        longint tab [STEPS] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
            29, 14, 7};
        return tab[i];
    endfunction

    function automatic void reduce_vector(ref longint v [3]);
        longint m;
        int     s;
        m = abs64(v[0]);
        if (abs64(v[1]) > m) m = abs64(v[1]);
        if (abs64(v[2]) > m) m = abs64(v[2]);
        s = 0;
        while ((m >>> s) > 64'sd1073741824) s++;
        for (int k = 0; k < 3; k++) begin
            v[k] = v[k] < 0 ? -(abs64(v[k]) >>> s) : (v[k] >>> s);
        end
    endfunction

    function automatic angle_result_t predict_angle(points_t p);
        angle_result_t r;
        longint        a [3];
        longint        b [3];
        longint        c [3];
        longint        dot, x, y, z, xs, ys, t;
        logic [127:0]  n, sq, cand, root, ym;
        int            g, g2;
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'(p[k]) - longint'(p[3+k]);
            b[k] = longint'(p[6+k]) - longint'(p[3+k]);
        end
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            r.angle = '0;
            r.zero_len = 1'b1;
            return r;
        end
        reduce_vector(a);
        reduce_vector(b);
        c[0] = a[1]*b[2] - a[2]*b[1];
        c[1] = a[2]*b[0] - a[0]*b[2];
        c[2] = a[0]*b[1] - a[1]*b[0];
        n = 128'(abs64(c[0])) * 128'(abs64(c[0])) + 128'(abs64(c[1])) * 128'(abs64(c[1]))
            + 128'(abs64(c[2])) * 128'(abs64(c[2]));
        dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        g = (124 - bit_length(n)) / 2;
        g2 = 62 - bit_length(128'(abs64(dot)));
        if (g2 < g) g = g2;
        sq = n << (2*g);
        root = '0;
        for (int i = 62; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            if (cand * cand <= sq) root = cand;
        end
        ym = 128'(abs64(dot)) << g;
        x = longint'(ym[63:0] >> 32);
        if (dot < 0) x = -x;
        y = longint'(root[63:0] >> 32);
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(90) << ZF;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(180) << ZF)) z = longint'(180) << ZF;
        z = (z + (longint'(1) << (ZF - AFB - 1))) >>> (ZF - AFB);
        r.angle = z[15:0];
        r.zero_len = 1'b0;
        return r;
    endfunction

    task automatic idle_gap(bit enable);
        if (enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_points(points_t p);
        logic [DATA_W-1:0] d;
        idle_gap(send_idle_on);
        d = '0;
        for (int k = 0; k < 9; k++) d[k*CW +: CW] = p[k];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_angles.push_back(predict_angle(p));
    endtask

    function automatic coord_t rand_coord(int bits);
        logic [31:0]        r;
        logic signed [31:0] s;
        r = $urandom();
        if (bits >= CW) return coord_t'(r[CW-1:0]);
        s = $signed(r << (32 - bits)) >>> (32 - bits);
        return coord_t'(s);
    endfunction

    function automatic points_t rand_points();
        points_t p;
        int      bits;
        bits = $urandom_range(1, CW);
        for (int k = 0; k < 9; k++) p[k] = rand_coord(bits);
        case ($urandom_range(0, 5))
            0: for (int k = 3; k < 6; k++) p[k] = '0;
            1: for (int k = 0; k < 3; k++) p[k] = p[3+k];
            2: for (int k = 0; k < 3; k++) p[6+k] = p[3+k] + p[k] - p[3+k];
            3: for (int k = 0; k < 3; k++) p[6+k] = p[3+k] - (p[k] - p[3+k]);
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        points_t p;
        coord_t  ext [4] = '{CMAX, CMIN, coord_t'(0), coord_t'(1)};
        p = '{default: '0};
        send_points(p);
        p = '{coord_t'(5), 0, 0, 0, 0, 0, 0, 0, 0};
        send_points(p);
        p = '{coord_t'(1), 0, 0, 0, 0, 0, 0, coord_t'(1), 0};
        send_points(p);
        p = '{coord_t'(1), 0, 0, 0, 0, 0, 0, coord_t'(-1), 0};
        send_points(p);
        p = '{coord_t'(1), 0, 0, 0, 0, 0, coord_t'(-1), 0, 0};
        send_points(p);
        p = '{coord_t'(1), 0, 0, 0, 0, 0, coord_t'(1), 0, 0};
        send_points(p);
        p = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN};
        send_points(p);
        p = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX};
        send_points(p);
        p = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX};
        send_points(p);
        p = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN};
        send_points(p);
        p = '{CMAX, 0, 0, 0, 0, 0, CMAX, coord_t'(1), 0};
        send_points(p);
        for (int i = 0; i < 12; i++) begin
            for (int k = 0; k < 9; k++) p[k] = ext[$urandom_range(0, 3)];
            send_points(p);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_points(rand_points());
    endtask

    task automatic test_output_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 120; i++) send_points(rand_points());
    endtask

    // receiver with random stalls and a long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            if (recv_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    initial begin
        angle_result_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t: unexpected transfer angle=%0d zero=%0d", $time,
                             m_axis_tdata, m_axis_tuser);
                    error_count++;
                end else begin
                    want = expected_angles.pop_front();
                    if (m_axis_tdata !== want.angle) begin
                        $display("%0t: angle expected %0d actual %0d", $time,
                                 want.angle, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.zero_len) begin
                        $display("%0t: zero_length expected %0d actual %0d", $time,
                                 want.zero_len, m_axis_tuser[0]);
                        error_count++;
                    end
                end
            end
        end
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        error_count   = 0;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        long_hold     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(420);
        test_output_backpressure();
        test_random(250);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random(140);
        s_axis_tvalid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
